@@ rtl/h264_sps_pps_extractor_unit_macros.svh @@
// Assertion helpers shared by the RTL files.
`ifndef H264_SPS_PPS_EXTRACTOR_UNIT_MACROS_SVH
`define H264_SPS_PPS_EXTRACTOR_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define H264SPE_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define H264SPE_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/h264spe_pkg.sv @@
`default_nettype none

package h264spe_pkg;

	localparam int unsigned DEF_PARAM_BYTES = 64;

	localparam logic [6:0] CAP_RESET = 7'd64;

	localparam logic [4:0] KIND_MASK = 5'h1f;
	localparam logic [4:0] KIND_SPS  = 5'd7;
	localparam logic [4:0] KIND_PPS  = 5'd8;

	// start code is 00 00 00 01; its three zero bytes are counted into the closing unit
	localparam int unsigned START_CODE_LEN = 4;
	localparam logic [8:0]  START_TAIL     = 9'(START_CODE_LEN - 1);

	localparam logic [7:0]  START_MARK   = 8'h01;
	localparam logic [23:0] HIST_EMPTY   = 24'hffffff;
	localparam logic [7:0]  COUNT_SAT    = 8'hff;

	typedef enum logic [1:0] {
		CMD_FEED   = 2'd0,
		CMD_RD_SPS = 2'd1,
		CMD_RD_PPS = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		ST_SCAN  = 2'd0,
		ST_DONE  = 2'd1,
		ST_ENDED = 2'd2
	} status_t;

	typedef enum logic {
		REG_SPS_CAP = 1'b0,
		REG_PPS_CAP = 1'b1
	} reg_idx_t;

	typedef struct packed {
		status_t    status;
		logic [6:0] sps_len;
		logic [6:0] pps_len;
		logic       sps_bank;
		logic       pps_bank;
	} scan_stat_t;

endpackage

`default_nettype wire

@@ rtl/h264spe_item_if.sv @@
`default_nettype none

interface h264spe_item_if;
	logic       valid;
	logic       ready;
	logic [1:0] command;
	logic [7:0] data_byte;
	logic       first_byte;
	logic       last_byte;
	logic [5:0] read_index;

	modport source (
		output valid, command, data_byte, first_byte, last_byte, read_index,
		input  ready
	);

	modport sink (
		input  valid, command, data_byte, first_byte, last_byte, read_index,
		output ready
	);
endinterface

`default_nettype wire

@@ rtl/h264spe_result_if.sv @@
`default_nettype none

interface h264spe_result_if;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic [6:0] sps_length;
	logic [6:0] pps_length;
	logic [7:0] read_data;

	modport source (
		output valid, status, sps_length, pps_length, read_data,
		input  ready
	);

	modport sink (
		input  valid, status, sps_length, pps_length, read_data,
		output ready
	);
endinterface

`default_nettype wire

@@ rtl/h264_sps_pps_extractor_unit.sv @@
// H.264 parameter set extractor. Feed the bytes of a frame one request at a time
// (command 0, first_byte on the opening byte, last_byte on the closing byte); the block
// hunts for 00 00 00 01 start codes, and when the next start code closes a type 7 or
// type 8 unit whose length (start code excluded) fits sps_capacity or pps_capacity it
// becomes the committed SPS or PPS. Commands 1 and 2 read a committed byte by index.
// Every request yields one result: status, both committed lengths and the read byte.
// Rate: one request per cycle while results are drained; the result is loaded into the
// output register on acceptance, and a new request is taken whenever that register is
// empty or being drained in the same cycle. The capture stores are two-bank byte
// memories with no clearing pass, so the block is ready straight out of reset.
// Capacity registers sit at byte addresses 0 (SPS) and 4 (PPS), reset to 64; write
// them only while no request is in flight.
`default_nettype none

`include "h264_sps_pps_extractor_unit_macros.svh"

module h264_sps_pps_extractor_unit
	import h264spe_pkg::*;
#(
	parameter int unsigned PARAM_BYTES = DEF_PARAM_BYTES
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	h264spe_item_if.sink     item,
	h264spe_result_if.source result,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	localparam int unsigned OW = $clog2(PARAM_BYTES);

	// configuration registers
	logic [6:0] sps_cap_q;
	logic [6:0] pps_cap_q;
	reg_idx_t   reg_sel;

	// handshake and output register
	logic       item_acc;
	logic       out_valid_q;
	status_t    status_q;
	logic [6:0] sps_len_q;
	logic [6:0] pps_len_q;
	logic       rd_hit_q;
	logic       rd_pps_q;

	// scanner and store hookup
	scan_stat_t    stat_cur;
	scan_stat_t    stat_nxt;
	logic          feed_en;
	logic          rd_sps_en;
	logic          rd_pps_en;
	logic          sps_we;
	logic          pps_we;
	logic          sps_wr_bank;
	logic          pps_wr_bank;
	logic [OW-1:0] wr_off;
	logic [OW-1:0] rd_off;
	logic [7:0]    sps_rd;
	logic [7:0]    pps_rd;

	// APB: writes land on the access phase, reads are combinational
	assign pready  = 1'b1;
	assign reg_sel = reg_idx_t'(paddr[2]);

	always_comb begin
		unique case (reg_sel)
			REG_SPS_CAP: prdata = {25'd0, sps_cap_q};
			REG_PPS_CAP: prdata = {25'd0, pps_cap_q};
			default:     prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sps_cap_q <= CAP_RESET;
			pps_cap_q <= CAP_RESET;
		end else if (psel && penable && pwrite && pready) begin
			unique case (reg_sel)
				REG_SPS_CAP: sps_cap_q <= pwdata[6:0];
				REG_PPS_CAP: pps_cap_q <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	// take a new request when the output register is free or draining
	assign item.ready = !out_valid_q || result.ready;
	assign item_acc   = item.valid && item.ready;

	// decode the request; reads past the committed length return zero
	always_comb begin
		feed_en   = 1'b0;
		rd_sps_en = 1'b0;
		rd_pps_en = 1'b0;
		if (item_acc) begin
			unique case (item.command)
				CMD_FEED:   feed_en   = 1'b1;
				CMD_RD_SPS: rd_sps_en = ({1'b0, item.read_index} < stat_cur.sps_len);
				CMD_RD_PPS: rd_pps_en = ({1'b0, item.read_index} < stat_cur.pps_len);
				default: ;
			endcase
		end
	end

	assign rd_off = OW'(item.read_index);

	h264spe_scan #(
		.PARAM_BYTES (PARAM_BYTES)
	) u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.feed_en     (feed_en),
		.data        (item.data_byte),
		.first       (item.first_byte),
		.last        (item.last_byte),
		.sps_cap     (sps_cap_q),
		.pps_cap     (pps_cap_q),
		.stat_cur    (stat_cur),
		.stat_nxt    (stat_nxt),
		.sps_we      (sps_we),
		.pps_we      (pps_we),
		.sps_wr_bank (sps_wr_bank),
		.pps_wr_bank (pps_wr_bank),
		.wr_off      (wr_off)
	);

	h264spe_store #(
		.PARAM_BYTES (PARAM_BYTES)
	) u_sps_store (
		.clk     (clk),
		.wr_en   (sps_we),
		.wr_bank (sps_wr_bank),
		.wr_off  (wr_off),
		.wr_data (item.data_byte),
		.rd_en   (rd_sps_en),
		.rd_bank (stat_cur.sps_bank),
		.rd_off  (rd_off),
		.rd_data (sps_rd)
	);

	h264spe_store #(
		.PARAM_BYTES (PARAM_BYTES)
	) u_pps_store (
		.clk     (clk),
		.wr_en   (pps_we),
		.wr_bank (pps_wr_bank),
		.wr_off  (wr_off),
		.wr_data (item.data_byte),
		.rd_en   (rd_pps_en),
		.rd_bank (stat_cur.pps_bank),
		.rd_off  (rd_off),
		.rd_data (pps_rd)
	);

	// result register: valid is control, the rest is payload loaded on acceptance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (item_acc) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_acc) begin
			status_q  <= stat_nxt.status;
			sps_len_q <= stat_nxt.sps_len;
			pps_len_q <= stat_nxt.pps_len;
			rd_hit_q  <= rd_sps_en || rd_pps_en;
			rd_pps_q  <= rd_pps_en;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.status     = status_q;
	assign result.sps_length = sps_len_q;
	assign result.pps_length = pps_len_q;
	assign result.read_data  = rd_hit_q ? (rd_pps_q ? pps_rd : sps_rd) : 8'h00;

	`H264SPE_ASSERT_IMP(a_no_overrun, clk, arst_n, out_valid_q && !result.ready, !item.ready,
		"request accepted over a stalled result")
	`H264SPE_ASSERT_NXT(a_valid_src, clk, arst_n, !out_valid_q && !item_acc, !out_valid_q,
		"result valid without an accepted request")
	`H264SPE_ASSERT_IMP(a_one_read, clk, arst_n, rd_sps_en, !rd_pps_en && !feed_en,
		"more than one store operation decoded")

endmodule

`default_nettype wire

@@ rtl/h264spe_store.sv @@
`default_nettype none

module h264spe_store
	import h264spe_pkg::*;
#(
	parameter int unsigned PARAM_BYTES = DEF_PARAM_BYTES,
	localparam int unsigned OW = $clog2(PARAM_BYTES),
	localparam int unsigned AW = $clog2(2 * PARAM_BYTES)
) (
	input  wire logic          clk,
	input  wire logic          wr_en,
	input  wire logic          wr_bank,
	input  wire logic [OW-1:0] wr_off,
	input  wire logic [7:0]    wr_data,
	input  wire logic          rd_en,
	input  wire logic          rd_bank,
	input  wire logic [OW-1:0] rd_off,
	output logic [7:0]         rd_data
);

	// two banks: one holds the committed copy, the other stages the unit in flight
	logic [7:0] mem_q [0:2*PARAM_BYTES-1];
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] rd_addr;

	assign wr_addr = wr_bank ? AW'(PARAM_BYTES) + AW'(wr_off) : AW'(wr_off);
	assign rd_addr = rd_bank ? AW'(PARAM_BYTES) + AW'(rd_off) : AW'(rd_off);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

@@ rtl/h264spe_scan.sv @@
`default_nettype none

`include "h264_sps_pps_extractor_unit_macros.svh"

module h264spe_scan
	import h264spe_pkg::*;
#(
	parameter int unsigned PARAM_BYTES = DEF_PARAM_BYTES,
	localparam int unsigned OW = $clog2(PARAM_BYTES)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          feed_en,
	input  wire logic [7:0]    data,
	input  wire logic          first,
	input  wire logic          last,
	input  wire logic [6:0]    sps_cap,
	input  wire logic [6:0]    pps_cap,
	output scan_stat_t         stat_cur,
	output scan_stat_t         stat_nxt,
	output logic               sps_we,
	output logic               pps_we,
	output logic               sps_wr_bank,
	output logic               pps_wr_bank,
	output logic [OW-1:0]      wr_off
);

	localparam logic [8:0] P9 = 9'(PARAM_BYTES);

	logic [23:0] recent_q, recent_n;
	logic        open_q, open_n;
	logic        hdr_q, hdr_n;
	logic [4:0]  kind_q, kind_n;
	logic [7:0]  cnt_q, cnt_n;
	logic        sps_bank_q, sps_bank_n;
	logic        pps_bank_q, pps_bank_n;
	logic        sps_held_q, sps_held_n;
	logic        pps_held_q, pps_held_n;
	logic [6:0]  sps_len_q, sps_len_n;
	logic [6:0]  pps_len_q, pps_len_n;
	logic        ended_q, ended_n;

	logic [8:0]  sps_lim, pps_lim;

	// capacity never exceeds one bank
	assign sps_lim = ({2'b00, sps_cap} > P9) ? P9 : {2'b00, sps_cap};
	assign pps_lim = ({2'b00, pps_cap} > P9) ? P9 : {2'b00, pps_cap};

	always_comb begin
		logic       stop;
		logic [8:0] size;
		recent_n   = recent_q;
		open_n     = open_q;
		hdr_n      = hdr_q;
		kind_n     = kind_q;
		cnt_n      = cnt_q;
		sps_bank_n = sps_bank_q;
		pps_bank_n = pps_bank_q;
		sps_held_n = sps_held_q;
		pps_held_n = pps_held_q;
		sps_len_n  = sps_len_q;
		pps_len_n  = pps_len_q;
		ended_n    = ended_q;
		sps_we     = 1'b0;
		pps_we     = 1'b0;
		stop       = 1'b0;
		size       = ({1'b0, cnt_q} >= START_TAIL) ? {1'b0, cnt_q} - START_TAIL : 9'd0;
		if (feed_en) begin
			if (first) begin
				open_n     = 1'b0;
				hdr_n      = 1'b0;
				kind_n     = '0;
				cnt_n      = '0;
				sps_held_n = 1'b0;
				pps_held_n = 1'b0;
				ended_n    = 1'b0;
				recent_n   = HIST_EMPTY;
			end else if ((sps_held_q && pps_held_q) || ended_q) begin
				stop = 1'b1;
			end
			if (!stop) begin
				if (recent_n == '0 && data == START_MARK && !last) begin
					// close the open unit and commit it if it fits
					if (open_n) begin
						if (kind_n == KIND_SPS && size <= sps_lim) begin
							sps_bank_n = ~sps_bank_q;
							sps_len_n  = 7'(size);
							sps_held_n = 1'b1;
						end else if (kind_n == KIND_PPS && size <= pps_lim) begin
							pps_bank_n = ~pps_bank_q;
							pps_len_n  = 7'(size);
							pps_held_n = 1'b1;
						end
					end
					open_n = 1'b1;
					hdr_n  = 1'b1;
					cnt_n  = '0;
				end else if (open_n) begin
					if (hdr_n) begin
						kind_n = data[4:0] & KIND_MASK;
						hdr_n  = 1'b0;
					end
					if ({1'b0, cnt_n} < P9) begin
						if (kind_n == KIND_SPS) begin
							sps_we = 1'b1;
						end else if (kind_n == KIND_PPS) begin
							pps_we = 1'b1;
						end
					end
					if (cnt_n != COUNT_SAT) begin
						cnt_n = cnt_n + 8'd1;
					end
				end
				recent_n = {recent_n[15:0], data};
				if (last && !(sps_held_n && pps_held_n)) begin
					ended_n = 1'b1;
				end
			end
		end
	end

	assign sps_wr_bank = ~sps_bank_q;
	assign pps_wr_bank = ~pps_bank_q;
	assign wr_off      = OW'(cnt_q);

	always_comb begin
		stat_cur.status   = (sps_held_q && pps_held_q) ? ST_DONE :
			(ended_q ? ST_ENDED : ST_SCAN);
		stat_cur.sps_len  = sps_len_q;
		stat_cur.pps_len  = pps_len_q;
		stat_cur.sps_bank = sps_bank_q;
		stat_cur.pps_bank = pps_bank_q;
		stat_nxt.status   = (sps_held_n && pps_held_n) ? ST_DONE :
			(ended_n ? ST_ENDED : ST_SCAN);
		stat_nxt.sps_len  = sps_len_n;
		stat_nxt.pps_len  = pps_len_n;
		stat_nxt.sps_bank = sps_bank_n;
		stat_nxt.pps_bank = pps_bank_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recent_q   <= '0;
			open_q     <= 1'b0;
			hdr_q      <= 1'b0;
			kind_q     <= '0;
			cnt_q      <= '0;
			sps_bank_q <= 1'b0;
			pps_bank_q <= 1'b0;
			sps_held_q <= 1'b0;
			pps_held_q <= 1'b0;
			sps_len_q  <= '0;
			pps_len_q  <= '0;
			ended_q    <= 1'b0;
		end else begin
			recent_q   <= recent_n;
			open_q     <= open_n;
			hdr_q      <= hdr_n;
			kind_q     <= kind_n;
			cnt_q      <= cnt_n;
			sps_bank_q <= sps_bank_n;
			pps_bank_q <= pps_bank_n;
			sps_held_q <= sps_held_n;
			pps_held_q <= pps_held_n;
			sps_len_q  <= sps_len_n;
			pps_len_q  <= pps_len_n;
			ended_q    <= ended_n;
		end
	end

	`H264SPE_ASSERT_IMP(a_wr_excl, clk, arst_n, sps_we, !pps_we, "both stores written at once")
	`H264SPE_ASSERT_NXT(a_commit_fits, clk, arst_n, $changed(sps_bank_q) || 1'b1,
		{2'b00, sps_len_q} <= P9, "committed length exceeds a bank")
	`H264SPE_ASSERT_NXT(a_idle_hold, clk, arst_n, !feed_en,
		$stable(sps_bank_q) && $stable(pps_bank_q) && $stable(cnt_q),
		"scan state moved without a fed byte")

endmodule

`default_nettype wire
